### rtl/pars_pkg.sv
`timescale 1ns / 1ps

package pars_pkg;

   localparam int unsigned Q_W        = 24;
   localparam int unsigned GAIN_W     = 16;
   localparam int unsigned FRAC_W     = 16;
   localparam int unsigned INDEX_W    = 3;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned STEP_W     = 4;
   localparam int unsigned MUL_A_W    = 25;
   localparam int unsigned MUL_B_W    = 26;
   localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
   localparam int unsigned SUM_W      = PROD_W - FRAC_W;
   localparam int unsigned RATE_COUNT = 7;

   localparam logic [Q_W-1:0] ONE_Q16 = 24'd65536;
   localparam logic [Q_W-1:0] Q_MAX   = 24'hFFFFFF;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_CHUNK_DURATION  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PROBE_GAIN      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PROBE_INCREMENT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SMOOTH_GAIN     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SAFETY_MARGIN   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_WAIT_GAIN       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_BUFFER   = 3'd6;

   localparam logic [Q_W-1:0]    RST_CHUNK_DURATION  = 24'd65536;
   localparam logic [GAIN_W-1:0] RST_PROBE_GAIN      = 16'd9175;
   localparam logic [Q_W-1:0]    RST_PROBE_INCREMENT = 24'd39322;
   localparam logic [GAIN_W-1:0] RST_SMOOTH_GAIN     = 16'd13107;
   localparam logic [GAIN_W-1:0] RST_SAFETY_MARGIN   = 16'd9830;
   localparam logic [GAIN_W-1:0] RST_WAIT_GAIN       = 16'd13107;
   localparam logic [Q_W-1:0]    RST_TARGET_BUFFER   = 24'd1179648;

   // 10, 6, 4, 3, 2, 1, 0.5 Mbps; the rate of index 7 has no entry and is never compared
   localparam logic [Q_W-1:0] RATE_TABLE [RATE_COUNT] = '{
      24'd655360, 24'd393216, 24'd262144, 24'd196608,
      24'd131072, 24'd65536, 24'd32768
   };

   typedef enum logic [1:0] {
      A_T,
      A_TK,
      A_Y,
      A_BETA
   } a_sel_type;

   typedef enum logic [2:0] {
      B_K,
      B_ALPHA,
      B_W_CAP,
      B_X_Y,
      B_ONE_EPS,
      B_BUF_DIFF
   } b_sel_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_START,
      OP_TK,
      OP_NX,
      OP_NY,
      OP_SAFE,
      OP_QUANT,
      OP_DONE,
      OP_FIRST
   } op_type;

   typedef enum logic [0:0] {
      JMP_NONE,
      JMP_FIRST
   } jmp_type;

   typedef struct packed {
      logic              mul_en;
      a_sel_type         a_sel;
      b_sel_type         b_sel;
      op_type            op;
      jmp_type           jmp;
      logic [STEP_W-1:0] target;
   } ucode_type;

   localparam logic [STEP_W-1:0] STEP_START = 4'd0;
   localparam logic [STEP_W-1:0] STEP_FIRST = 4'd13;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] addr);
      ucode_type w;
      w = '{mul_en: 1'b0, a_sel: A_T, b_sel: B_K, op: OP_NOP, jmp: JMP_NONE,
            target: STEP_START};
      unique case (addr)
         4'd0: begin
            w.op = OP_START;
            w.jmp = JMP_FIRST;
            w.target = STEP_FIRST;
         end
         4'd1: begin
            w.mul_en = 1'b1; w.a_sel = A_T; w.b_sel = B_K;
         end
         4'd2: w.op = OP_TK;
         4'd3: begin
            w.mul_en = 1'b1; w.a_sel = A_TK; w.b_sel = B_W_CAP;
         end
         4'd4: w.op = OP_NX;
         4'd5: begin
            w.mul_en = 1'b1; w.a_sel = A_T; w.b_sel = B_ALPHA;
         end
         4'd6: w.op = OP_TK;
         4'd7: begin
            w.mul_en = 1'b1; w.a_sel = A_TK; w.b_sel = B_X_Y;
         end
         4'd8: w.op = OP_NY;
         4'd9: begin
            w.mul_en = 1'b1; w.a_sel = A_Y; w.b_sel = B_ONE_EPS;
         end
         4'd10: w.op = OP_SAFE;
         4'd11: begin
            w.mul_en = 1'b1; w.a_sel = A_BETA; w.b_sel = B_BUF_DIFF;
            w.op = OP_QUANT;
         end
         4'd12: w.op = OP_DONE;
         4'd13: w.op = OP_FIRST;
         default: w.op = OP_NOP;
      endcase
      return w;
   endfunction

   function automatic logic [Q_W-1:0] clamp_q(input logic signed [SUM_W-1:0] v);
      if (v < 0)
         return '0;
      if (v > $signed({{(SUM_W-Q_W){1'b0}}, Q_MAX}))
         return Q_MAX;
      return v[Q_W-1:0];
   endfunction

endpackage

### rtl/probe_adapt_rate_selector_core.sv
`timescale 1ns / 1ps

// channel   | handshake             | payload
// ----------+-----------------------+-----------------------------------------------
// request   | req_valid / req_ready | req_throughput, req_buffer_level
// response  | rsp_valid / rsp_ready | rsp_rate_index, rsp_wait_time, rsp_smoothed_rate
// config    | csr_we                | csr_index, csr_wdata
//
// A request runs 13 microcode steps after it is accepted; the first one after reset
// jumps from the start step straight to the first-decision step. The steps share the
// single 25x26 multiplier and the register after it. Reset is synchronous. A request
// is accepted while the previous response still waits; the final step stalls until the
// response register is free. No new request is taken while the program runs.

module probe_adapt_rate_selector_core
   import pars_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [Q_W-1:0]         req_throughput,
   input  logic [Q_W-1:0]         req_buffer_level,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [INDEX_W-1:0]     rsp_rate_index,
   output logic [Q_W-1:0]         rsp_wait_time,
   output logic [Q_W-1:0]         rsp_smoothed_rate,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [Q_W-1:0]         csr_wdata
);

   logic [Q_W-1:0]    chunk_ff, incr_ff, target_ff;
   logic [GAIN_W-1:0] pgain_ff, sgain_ff, margin_ff, wgain_ff;

   logic              run_ff;
   logic [STEP_W-1:0] step_ff;
   logic [1:0]        count_ff;
   logic [Q_W-1:0]    x_ff, y_ff;
   logic [INDEX_W-1:0] prev_ff;

   logic [Q_W-1:0]    thr_ff, buf_ff, tk_ff, safe_ff;
   logic signed [PROD_W-1:0] prod_ff;

   logic                  rsp_valid_ff;
   logic [INDEX_W-1:0]    rsp_index_ff;
   logic [Q_W-1:0]        rsp_wait_ff, rsp_smooth_ff;

   ucode_type             uc;
   logic [STEP_W-1:0]     step_in;
   logic                  rsp_load;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_in;
   logic [Q_W-1:0]        cap;
   logic signed [SUM_W-1:0] nx_sum, ny_sum;
   logic [INDEX_W-1:0]    up_cnt, down_cnt, idx_in;
   logic [Q_W-1:0]        wait_in;
   logic                  req_accept, out_free;

   assign req_ready  = !run_ff;
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_load   = run_ff && out_free && (uc.op == OP_DONE || uc.op == OP_FIRST);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rate_index    = rsp_index_ff;
   assign rsp_wait_time     = rsp_wait_ff;
   assign rsp_smoothed_rate = rsp_smooth_ff;

   always_comb begin
      uc = ucode_rom(step_ff);
   end

   // next step: advance, jump on the first decision, hold while the response waits
   always_comb begin
      step_in = step_ff + 1'b1;
      if (uc.jmp == JMP_FIRST && count_ff == 2'd0)
         step_in = uc.target;
      if ((uc.op == OP_DONE || uc.op == OP_FIRST) && !out_free)
         step_in = step_ff;
   end

   // shared multiplier operands
   always_comb begin
      cap = (x_ff > thr_ff) ? (x_ff - thr_ff) : '0;
      case (uc.a_sel)
         A_T:     mul_a = $signed({1'b0, chunk_ff});
         A_TK:    mul_a = $signed({1'b0, tk_ff});
         A_Y:     mul_a = $signed({1'b0, y_ff});
         A_BETA:  mul_a = $signed({{(MUL_A_W-GAIN_W){1'b0}}, wgain_ff});
         default: mul_a = '0;
      endcase
      case (uc.b_sel)
         B_K:        mul_b = $signed({{(MUL_B_W-GAIN_W){1'b0}}, pgain_ff});
         B_ALPHA:    mul_b = $signed({{(MUL_B_W-GAIN_W){1'b0}}, sgain_ff});
         B_W_CAP:    mul_b = $signed({2'b00, incr_ff}) - $signed({2'b00, cap});
         B_X_Y:      mul_b = $signed({2'b00, x_ff}) - $signed({2'b00, y_ff});
         B_ONE_EPS:  mul_b = $signed({2'b00, ONE_Q16})
                             - $signed({{(MUL_B_W-GAIN_W){1'b0}}, margin_ff});
         B_BUF_DIFF: mul_b = $signed({2'b00, buf_ff}) - $signed({2'b00, target_ff});
         default:    mul_b = '0;
      endcase
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      nx_sum = $signed({{(SUM_W-Q_W){1'b0}}, x_ff}) + $signed(prod_ff[PROD_W-1:FRAC_W]);
      ny_sum = $signed({{(SUM_W-Q_W){1'b0}}, y_ff}) + $signed(prod_ff[PROD_W-1:FRAC_W]);
      wait_in = (buf_ff > target_ff) ? prod_ff[FRAC_W+Q_W-1:FRAC_W] : '0;
   end

   // quantizer with dead zone
   always_comb begin
      up_cnt   = '0;
      down_cnt = '0;
      for (int i = 0; i < RATE_COUNT; i++) begin
         up_cnt   = up_cnt + INDEX_W'(RATE_TABLE[i] > safe_ff);
         down_cnt = down_cnt + INDEX_W'(RATE_TABLE[i] > y_ff);
      end
      idx_in = prev_ff;
      if (idx_in > up_cnt)
         idx_in = up_cnt;
      if (idx_in < down_cnt)
         idx_in = down_cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff     <= RST_CHUNK_DURATION;
         pgain_ff     <= RST_PROBE_GAIN;
         incr_ff      <= RST_PROBE_INCREMENT;
         sgain_ff     <= RST_SMOOTH_GAIN;
         margin_ff    <= RST_SAFETY_MARGIN;
         wgain_ff     <= RST_WAIT_GAIN;
         target_ff    <= RST_TARGET_BUFFER;
         run_ff       <= 1'b0;
         step_ff      <= STEP_START;
         count_ff     <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_CHUNK_DURATION:  chunk_ff  <= csr_wdata;
               REG_PROBE_GAIN:      pgain_ff  <= csr_wdata[GAIN_W-1:0];
               REG_PROBE_INCREMENT: incr_ff   <= csr_wdata;
               REG_SMOOTH_GAIN:     sgain_ff  <= csr_wdata[GAIN_W-1:0];
               REG_SAFETY_MARGIN:   margin_ff <= csr_wdata[GAIN_W-1:0];
               REG_WAIT_GAIN:       wgain_ff  <= csr_wdata[GAIN_W-1:0];
               REG_TARGET_BUFFER:   target_ff <= csr_wdata;
               default: ;
            endcase
         end

         if (rsp_load)
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready)
            rsp_valid_ff <= 1'b0;

         if (req_accept) begin
            thr_ff  <= req_throughput;
            buf_ff  <= req_buffer_level;
            run_ff  <= 1'b1;
            step_ff <= STEP_START;
         end else if (run_ff) begin
            step_ff <= step_in;
            if (uc.mul_en)
               prod_ff <= prod_in;
            unique case (uc.op)
               OP_NOP: ;
               OP_START: begin
                  if (count_ff == 2'd1)
                     x_ff <= thr_ff >> 1;
                  if (count_ff != 2'd0)
                     count_ff <= 2'd2;
               end
               OP_TK:    tk_ff   <= prod_ff[FRAC_W+Q_W-1:FRAC_W];
               OP_NX:    x_ff    <= clamp_q(nx_sum);
               OP_NY:    y_ff    <= clamp_q(ny_sum);
               OP_SAFE:  safe_ff <= prod_ff[FRAC_W+Q_W-1:FRAC_W];
               OP_QUANT: prev_ff <= idx_in;
               OP_DONE: begin
                  if (out_free) begin
                     rsp_index_ff  <= prev_ff;
                     rsp_wait_ff   <= wait_in;
                     rsp_smooth_ff <= y_ff;
                     run_ff        <= 1'b0;
                  end
               end
               OP_FIRST: begin
                  if (out_free) begin
                     rsp_index_ff  <= '0;
                     rsp_wait_ff   <= '0;
                     rsp_smooth_ff <= y_ff;
                     count_ff      <= 2'd1;
                     run_ff        <= 1'b0;
                  end
               end
               default: ;
            endcase
         end
      end
   end

`ifndef ASSERT_OFF
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> run_ff && step_ff == STEP_START)
      else $error("request accepted without starting the program");

   a_rsp_from_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(run_ff) && !run_ff)
      else $error("response raised outside the final step");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> step_ff <= STEP_FIRST)
      else $error("step counter left the program");

   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("decision count beyond saturation");
`endif

endmodule

### tb/sv/probe_adapt_decision_checker.sv
`timescale 1ns / 1ps

module probe_adapt_decision_checker
   import pars_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [Q_W-1:0]         req_throughput,
   input  logic [Q_W-1:0]         req_buffer_level,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [INDEX_W-1:0]     rsp_rate_index,
   input  logic [Q_W-1:0]         rsp_wait_time,
   input  logic [Q_W-1:0]         rsp_smoothed_rate,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [Q_W-1:0]         csr_wdata,
   input  logic                   drain_check,
   output int                     outstanding,
   output int                     mismatches,
   output logic [7:0]             index_seen
);

   localparam longint UNIT = 64'd65536;

   typedef struct packed {
      logic [INDEX_W-1:0] rate_index;
      logic [Q_W-1:0]     wait_time;
      logic [Q_W-1:0]     smoothed_rate;
   } decision_type;

   logic [Q_W-1:0]     cfg_chunk;
   logic [GAIN_W-1:0]  cfg_probe_gain;
   logic [Q_W-1:0]     cfg_probe_inc;
   logic [GAIN_W-1:0]  cfg_smooth_gain;
   logic [GAIN_W-1:0]  cfg_margin;
   logic [GAIN_W-1:0]  cfg_wait_gain;
   logic [Q_W-1:0]     cfg_target;

   logic [1:0]         decisions;
   logic [Q_W-1:0]     probe_q;
   logic [Q_W-1:0]     smooth_q;
   logic [INDEX_W-1:0] prev_index;

   decision_type pending_decisions[$];

   function automatic longint sat_q(input longint v);
      if (v < 0)
         return 0;
      if (v > longint'(Q_MAX))
         return longint'(Q_MAX);
      return v;
   endfunction

   // bitrate ladder, highest first
   function automatic longint ladder_rate(input int step);
      case (step)
         0: return 10 * UNIT;
         1: return 6 * UNIT;
         2: return 4 * UNIT;
         3: return 3 * UNIT;
         4: return 2 * UNIT;
         5: return UNIT;
         default: return UNIT / 2;
      endcase
   endfunction

   task automatic predict_decision(input logic [Q_W-1:0] thr, input logic [Q_W-1:0] level,
                                   output decision_type d);
      longint over, tk, ta, nx, ny, safe, hold;
      int unsigned up_cnt, down_cnt;
      logic [INDEX_W-1:0] idx;
      if (decisions == 2'd0) begin
         decisions = 2'd1;
         d.rate_index    = '0;
         d.wait_time     = '0;
         d.smoothed_rate = smooth_q;
         return;
      end
      if (decisions == 2'd1)
         probe_q = thr >> 1;
      decisions = 2'd2;

      over = longint'(probe_q) - longint'(thr);
      if (over < 0)
         over = 0;
      tk = (longint'(cfg_chunk) * longint'(cfg_probe_gain)) >>> 16;
      nx = sat_q(longint'(probe_q) + ((tk * (longint'(cfg_probe_inc) - over)) >>> 16));
      ta = (longint'(cfg_chunk) * longint'(cfg_smooth_gain)) >>> 16;
      ny = sat_q(longint'(smooth_q) + ((ta * (nx - longint'(smooth_q))) >>> 16));
      safe = (ny * (UNIT - longint'(cfg_margin))) >>> 16;

      up_cnt   = 0;
      down_cnt = 0;
      for (int i = 0; i < 7; i++) begin
         if (ladder_rate(i) > safe)
            up_cnt++;
         if (ladder_rate(i) > ny)
            down_cnt++;
      end
      // dead zone: previous index survives if it sits between the two bounds
      idx = prev_index;
      if (idx > up_cnt)
         idx = INDEX_W'(up_cnt);
      if (idx < down_cnt)
         idx = INDEX_W'(down_cnt);

      hold = 0;
      if (level > cfg_target)
         hold = (longint'(cfg_wait_gain) * (longint'(level) - longint'(cfg_target))) >>> 16;
      hold = sat_q(hold);

      probe_q    = nx[Q_W-1:0];
      smooth_q   = ny[Q_W-1:0];
      prev_index = idx;

      d.rate_index    = idx;
      d.wait_time     = hold[Q_W-1:0];
      d.smoothed_rate = ny[Q_W-1:0];
   endtask

   always @(posedge clock) begin : watch
      decision_type want, got;
      if (reset) begin
         cfg_chunk       = RST_CHUNK_DURATION;
         cfg_probe_gain  = RST_PROBE_GAIN;
         cfg_probe_inc   = RST_PROBE_INCREMENT;
         cfg_smooth_gain = RST_SMOOTH_GAIN;
         cfg_margin      = RST_SAFETY_MARGIN;
         cfg_wait_gain   = RST_WAIT_GAIN;
         cfg_target      = RST_TARGET_BUFFER;
         decisions       = 2'd0;
         probe_q         = '0;
         smooth_q        = '0;
         prev_index      = '0;
         mismatches      = 0;
         pending_decisions.delete();
         outstanding <= 0;
         index_seen  <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_CHUNK_DURATION:  cfg_chunk       = csr_wdata;
               REG_PROBE_GAIN:      cfg_probe_gain  = csr_wdata[GAIN_W-1:0];
               REG_PROBE_INCREMENT: cfg_probe_inc   = csr_wdata;
               REG_SMOOTH_GAIN:     cfg_smooth_gain = csr_wdata[GAIN_W-1:0];
               REG_SAFETY_MARGIN:   cfg_margin      = csr_wdata[GAIN_W-1:0];
               REG_WAIT_GAIN:       cfg_wait_gain   = csr_wdata[GAIN_W-1:0];
               REG_TARGET_BUFFER:   cfg_target      = csr_wdata;
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            predict_decision(req_throughput, req_buffer_level, want);
            pending_decisions.insert(pending_decisions.size(), want);
         end

         if (rsp_valid && rsp_ready) begin
            got = '{rsp_rate_index, rsp_wait_time, rsp_smoothed_rate};
            if (pending_decisions.size() == 0) begin
               $display("%0t: unexpected response: index %0d wait %h rate %h",
                        $time, got.rate_index, got.wait_time, got.smoothed_rate);
               mismatches++;
            end else begin
               want = pending_decisions.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch index/wait/rate: expected %0d/%h/%h, got %0d/%h/%h",
                           $time, want.rate_index, want.wait_time, want.smoothed_rate,
                           got.rate_index, got.wait_time, got.smoothed_rate);
                  mismatches++;
               end
               if (!$isunknown(got.rate_index))
                  index_seen[got.rate_index] <= 1'b1;
            end
         end

         if (drain_check) begin
            while (pending_decisions.size() > 0) begin
               want = pending_decisions.pop_front();
               $display("%0t: missing response: expected index %0d wait %h rate %h",
                        $time, want.rate_index, want.wait_time, want.smoothed_rate);
               mismatches++;
            end
         end

         outstanding <= pending_decisions.size();
      end
   end

endmodule

### tb/sv/tb_probe_adapt_rate_selector_core.sv
`timescale 1ns / 1ps

module tb_probe_adapt_rate_selector_core;
   import pars_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 92;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;
   localparam logic [Q_W-1:0] MBPS = 24'd65536;

   typedef struct {
      logic [Q_W-1:0] chunk;
      logic [Q_W-1:0] probe_gain;
      logic [Q_W-1:0] probe_inc;
      logic [Q_W-1:0] smooth_gain;
      logic [Q_W-1:0] margin;
      logic [Q_W-1:0] wait_gain;
      logic [Q_W-1:0] target;
   } reg_set_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [Q_W-1:0]         req_throughput = '0;
   logic [Q_W-1:0]         req_buffer_level = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [INDEX_W-1:0]     rsp_rate_index;
   logic [Q_W-1:0]         rsp_wait_time;
   logic [Q_W-1:0]         rsp_smoothed_rate;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = REG_CHUNK_DURATION;
   logic [Q_W-1:0]         csr_wdata = '0;
   logic                   drain_check = 1'b0;

   int         outstanding;
   int         mismatches;
   logic [7:0] index_seen;
   int         cycles = 0;
   int         stall_left = 0;
   logic       calm = 1'b0;
   int         requests_sent = 0;
   int         settings_used = 0;
   logic [Q_W-1:0] thr_base = '0;

   probe_adapt_rate_selector_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_throughput    (req_throughput),
      .req_buffer_level  (req_buffer_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_rate_index    (rsp_rate_index),
      .rsp_wait_time     (rsp_wait_time),
      .rsp_smoothed_rate (rsp_smoothed_rate),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   probe_adapt_decision_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_throughput    (req_throughput),
      .req_buffer_level  (req_buffer_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_rate_index    (rsp_rate_index),
      .rsp_wait_time     (rsp_wait_time),
      .rsp_smoothed_rate (rsp_smoothed_rate),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .drain_check       (drain_check),
      .outstanding       (outstanding),
      .mismatches        (mismatches),
      .index_seen        (index_seen)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
   end

   // response side: stall counts only while a response is offered
   always @(posedge clock) begin : rsp_side
      int stall;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && rsp_ready) begin
         stall = calm ? 0 : $urandom_range(0, 5);
         stall_left <= stall;
         rsp_ready  <= (stall == 0);
      end else if (rsp_valid && stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= (stall_left == 1);
      end else begin
         rsp_ready <= (stall_left == 0);
      end
   end

   initial begin
      wait (cycles >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles, %0d responses outstanding", cycles, outstanding);
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_request(input logic [Q_W-1:0] thr, input logic [Q_W-1:0] level);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_throughput   <= thr;
      req_buffer_level <= level;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic apply_settings(input reg_set_type s, input bit poke_unused);
      csr_we <= 1'b1;
      csr_index <= REG_CHUNK_DURATION;  csr_wdata <= s.chunk;       @(posedge clock);
      csr_index <= REG_PROBE_GAIN;      csr_wdata <= s.probe_gain;  @(posedge clock);
      csr_index <= REG_PROBE_INCREMENT; csr_wdata <= s.probe_inc;   @(posedge clock);
      csr_index <= REG_SMOOTH_GAIN;     csr_wdata <= s.smooth_gain; @(posedge clock);
      csr_index <= REG_SAFETY_MARGIN;   csr_wdata <= s.margin;      @(posedge clock);
      csr_index <= REG_WAIT_GAIN;       csr_wdata <= s.wait_gain;   @(posedge clock);
      csr_index <= REG_TARGET_BUFFER;   csr_wdata <= s.target;      @(posedge clock);
      if (poke_unused) begin
         csr_index <= REG_UNUSED; csr_wdata <= Q_W'($urandom); @(posedge clock);
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   function automatic reg_set_type draw_settings(input int kind);
      reg_set_type s;
      case (kind)
         0: s = '{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX};
         1: s = '{'0, '0, '0, '0, '0, '0, '0};
         2: s = '{RST_CHUNK_DURATION, Q_W'(RST_PROBE_GAIN), RST_PROBE_INCREMENT,
                  Q_W'(RST_SMOOTH_GAIN), Q_W'(RST_SAFETY_MARGIN), Q_W'(RST_WAIT_GAIN),
                  RST_TARGET_BUFFER};
         default: begin
            s.chunk = ($urandom_range(0, 3) == 0) ? Q_W'($urandom)
                                                  : Q_W'($urandom_range(16384, 196608));
            s.probe_gain  = Q_W'($urandom);
            s.probe_inc   = ($urandom_range(0, 3) == 0) ? Q_W'($urandom)
                                                        : Q_W'($urandom_range(0, 262144));
            s.smooth_gain = Q_W'($urandom);
            s.margin      = Q_W'($urandom);
            s.wait_gain   = Q_W'($urandom);
            s.target      = ($urandom_range(0, 3) == 0) ? Q_W'($urandom)
                                                        : Q_W'($urandom_range(0, 2621440));
         end
      endcase
      return s;
   endfunction

   function automatic logic [Q_W-1:0] draw_throughput();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel == 0)
         return $urandom_range(0, 1) ? Q_MAX : '0;
      if (sel == 1)
         return Q_W'($urandom);
      // mostly a jittered level around the current link rate
      return thr_base + Q_W'($urandom_range(0, 65536)) - Q_W'($urandom_range(0, 65536));
   endfunction

   function automatic logic [Q_W-1:0] draw_level(input logic [Q_W-1:0] target);
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel == 0)
         return target + Q_W'($urandom_range(0, 8)) - Q_W'(4);
      if (sel <= 2)
         return Q_W'($urandom);
      return Q_W'($urandom_range(0, 2621440));
   endfunction

   initial begin : stimulus
      reg_set_type s;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // defaults: first decision, probe seeding, field extremes, buffer around target
      send_request(Q_W'(5 * MBPS), '0);
      send_request('0, '0);
      send_request(Q_MAX, Q_MAX);
      send_request('0, RST_TARGET_BUFFER);
      send_request(Q_MAX, RST_TARGET_BUFFER + 24'd1);
      send_request(Q_W'(10 * MBPS), RST_TARGET_BUFFER - 24'd1);
      drain();

      // fast gains: walk the smoothed rate up the ladder and back down
      s = '{MBPS, 24'h00FFFF, Q_W'(10 * MBPS), 24'h00FFFF, '0, 24'h00FFFF, '0};
      apply_settings(s, 1'b0);
      send_request(Q_W'(12 * MBPS), Q_MAX);
      send_request(Q_W'(12 * MBPS), '0);
      send_request(Q_W'(12 * MBPS), 24'd1);
      for (int i = 0; i < 10; i++)
         send_request(Q_W'(Q_W'(i) * (MBPS / 4)), Q_W'(20 * MBPS));
      drain();

      for (int p = 0; p < PHASES; p++) begin
         s = draw_settings(p);
         apply_settings(s, p == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 20 == 0) begin
               calm     <= ($urandom_range(0, 3) == 0);
               thr_base <= Q_W'($urandom_range(0, 786432));
            end
            send_request(draw_throughput(), draw_level(s.target));
         end
         drain();
      end

      repeat (20) @(posedge clock);
      drain_check <= 1'b1;
      repeat (2) @(posedge clock);
      $display("Ran %0d requests under %0d register settings with random gaps and stalls",
               requests_sent, settings_used + 1);
      $display("Rate indices returned (bit per index): %b", index_seen);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
